### design/rpn_pkg.sv
// Package: shared widths, symbol codes, status codes and stack cell controls.
package rpn_pkg;

    localparam int DATA_W            = 32;
    localparam int SYM_W             = 7;
    localparam int STATUS_W          = 3;
    localparam int STACK_DEPTH_DEF   = 32;

    typedef logic [DATA_W-1:0]   t_data;
    typedef logic [SYM_W-1:0]    t_sym;
    typedef logic [STATUS_W-1:0] t_status;

    // Stack cell controls
    typedef logic [1:0] t_cell_op;
    localparam t_cell_op CELL_HOLD = 2'd0;
    localparam t_cell_op CELL_PUSH = 2'd1;   // take the value from the cell above
    localparam t_cell_op CELL_POP  = 2'd2;   // take the value from the cell below

    // Result status codes
    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_OVERFLOW  = 3'd1;
    localparam t_status ST_UNDERFLOW = 3'd2;
    localparam t_status ST_DIVZERO   = 3'd3;
    localparam t_status ST_DEPTH     = 3'd4;
    localparam t_status ST_SYMBOL    = 3'd5;

    // Symbol codes
    localparam t_sym SYM_PLUS  = 7'h2B;
    localparam t_sym SYM_MINUS = 7'h2D;
    localparam t_sym SYM_MUL   = 7'h2A;
    localparam t_sym SYM_DIV   = 7'h2F;
    localparam t_sym SYM_ZERO  = 7'h30;
    localparam t_sym SYM_NINE  = 7'h39;
    localparam t_sym SYM_LOW_A = 7'h61;
    localparam t_sym SYM_LOW_Z = 7'h7A;

endpackage

### design/rpn_if.sv
// Interfaces: symbol request channel and result channel.
interface rpn_sym_if;
    logic              valid;
    logic              ready;
    rpn_pkg::t_sym     symbol;
    logic              last;

    modport source (output valid, output symbol, output last, input ready);
    modport sink   (input valid, input symbol, input last, output ready);
endinterface

interface rpn_res_if;
    logic                        valid;
    logic                        ready;
    logic signed [rpn_pkg::DATA_W-1:0] value;
    rpn_pkg::t_status            status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

### design/rpn_cell.sv
// Stack cell: one operand entry that shifts down on push and up on pop.
module rpn_cell (
    input  logic              i_clk,
    input  rpn_pkg::t_cell_op i_op,
    input  rpn_pkg::t_data    i_up,
    input  rpn_pkg::t_data    i_down,
    output rpn_pkg::t_data    o_val
);
    import rpn_pkg::*;

    t_data r_val;

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            CELL_PUSH: r_val <= i_up;
            CELL_POP:  r_val <= i_down;
            default:   r_val <= r_val;
        endcase
    end

    assign o_val = r_val;

endmodule

### design/rpn_divider.sv
// Iterative signed divider: one quotient bit per cycle, truncating toward zero.
module rpn_divider (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  rpn_pkg::t_data i_dividend,
    input  rpn_pkg::t_data i_divisor,
    output logic           o_done,
    output rpn_pkg::t_data o_quotient
);
    import rpn_pkg::*;

    localparam int STEP_W = $clog2(DATA_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DATA_W:0]   r_rem;
    t_data             r_quo;
    t_data             r_div;
    logic              r_neg;

    t_data           w_a_mag;
    t_data           w_b_mag;
    logic [DATA_W:0] w_shift;
    logic [DATA_W:0] w_trial;

    assign w_a_mag = i_dividend[DATA_W-1] ? (t_data'(0) - i_dividend) : i_dividend;
    assign w_b_mag = i_divisor[DATA_W-1]  ? (t_data'(0) - i_divisor)  : i_divisor;
    assign w_shift = {r_rem[DATA_W-1:0], r_quo[DATA_W-1]};
    assign w_trial = w_shift - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= w_a_mag;
            r_div <= w_b_mag;
            r_neg <= i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
        end else if (r_busy) begin
            // keep the trial remainder only when it did not go negative
            r_rem <= w_trial[DATA_W] ? w_shift : w_trial;
            r_quo <= {r_quo[DATA_W-2:0], ~w_trial[DATA_W]};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (t_data'(0) - r_quo) : r_quo;

endmodule

### design/postfix_expression_evaluator_core.sv
// Postfix expression evaluator: top level with stack cell chain, divider and control.
//
// Symbols of a postfix expression arrive one request at a time, the last one
// flagged. Letters a-z push 1-26, digits push 0-9, and + - * / combine the two
// top entries with 32-bit wrap; / truncates toward zero. The operand stack is a
// chain of STACK_DEPTH cells that shift down on a push and up on a pop, so the
// two top entries always sit in fixed cells. A push or + - * updates the stack at
// once; a / waits while the bit-serial divider makes one quotient bit a cycle. One
// result comes out on the last symbol, or at once on the first error (value 0,
// status code); symbols after an error are dropped up to the last one. A new
// symbol is taken when no / runs and the result register is free or being drained.
module postfix_expression_evaluator_core #(
    parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rpn_sym_if.sink        i_sym,
    rpn_res_if.source      o_res
);
    import rpn_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DIV  = 1'b1;

    logic             r_state;
    logic             n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_err_seen;
    logic             n_err_seen;
    logic             r_last;
    logic             n_last;

    logic             r_out_valid;
    t_data            r_out_value;
    t_status          r_out_status;

    t_data            w_cell [STACK_DEPTH];
    t_cell_op         w_op_head;
    t_cell_op         w_op_tail;
    t_data            w_head_val;

    logic             w_emit;
    t_data            w_emit_value;
    t_status          w_emit_status;
    logic             w_div_start;
    logic             w_div_done;
    t_data            w_quotient;

    logic             w_accept;
    logic             w_is_lower;
    logic             w_is_digit;
    logic             w_is_op;
    t_data            w_push_val;
    t_data            w_prod;

    // stack cell chain
    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            rpn_cell u_cell (
                .i_clk  (i_clk),
                .i_op   (w_op_head),
                .i_up   (w_head_val),
                .i_down (w_cell[1]),
                .o_val  (w_cell[0])
            );
        end else if (g == STACK_DEPTH - 1) begin : g_foot
            rpn_cell u_cell (
                .i_clk  (i_clk),
                .i_op   (w_op_tail),
                .i_up   (w_cell[g-1]),
                .i_down ('0),
                .o_val  (w_cell[g])
            );
        end else begin : g_mid
            rpn_cell u_cell (
                .i_clk  (i_clk),
                .i_op   (w_op_tail),
                .i_up   (w_cell[g-1]),
                .i_down (w_cell[g+1]),
                .o_val  (w_cell[g])
            );
        end
    end

    rpn_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_cell[1]),
        .i_divisor  (w_cell[0]),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    assign i_sym.ready = (r_state == S_IDLE) && (!r_out_valid || o_res.ready);
    assign w_accept    = i_sym.valid && i_sym.ready;

    assign w_is_lower = (i_sym.symbol >= SYM_LOW_A) && (i_sym.symbol <= SYM_LOW_Z);
    assign w_is_digit = (i_sym.symbol >= SYM_ZERO) && (i_sym.symbol <= SYM_NINE);
    assign w_is_op    = (i_sym.symbol == SYM_PLUS) || (i_sym.symbol == SYM_MINUS) ||
                        (i_sym.symbol == SYM_MUL)  || (i_sym.symbol == SYM_DIV);
    assign w_push_val = w_is_lower ? DATA_W'(i_sym.symbol - SYM_LOW_A + SYM_W'(1))
                                   : DATA_W'(i_sym.symbol - SYM_ZERO);
    assign w_prod     = w_cell[1] * w_cell[0];

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_err_seen    = r_err_seen;
        n_last        = r_last;
        w_op_head     = CELL_HOLD;
        w_op_tail     = CELL_HOLD;
        w_head_val    = w_push_val;
        w_emit        = 1'b0;
        w_emit_value  = '0;
        w_emit_status = ST_OK;
        w_div_start   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (r_err_seen) begin
                        // drop until the last symbol
                        if (i_sym.last) begin
                            n_err_seen = 1'b0;
                        end
                    end else if (w_is_lower || w_is_digit) begin
                        if (r_count >= CNT_W'(STACK_DEPTH)) begin
                            w_emit        = 1'b1;
                            w_emit_status = ST_OVERFLOW;
                        end else begin
                            w_op_head = CELL_PUSH;
                            w_op_tail = CELL_PUSH;
                            n_count   = r_count + CNT_W'(1);
                        end
                    end else if (w_is_op) begin
                        if (r_count < CNT_W'(2)) begin
                            w_emit        = 1'b1;
                            w_emit_status = ST_UNDERFLOW;
                        end else if (i_sym.symbol == SYM_DIV) begin
                            if (w_cell[0] == '0) begin
                                w_emit        = 1'b1;
                                w_emit_status = ST_DIVZERO;
                            end else begin
                                w_div_start = 1'b1;
                                n_last      = i_sym.last;
                                n_state     = S_DIV;
                            end
                        end else begin
                            case (i_sym.symbol)
                                SYM_PLUS:  w_head_val = w_cell[1] + w_cell[0];
                                SYM_MINUS: w_head_val = w_cell[1] - w_cell[0];
                                default:   w_head_val = w_prod;
                            endcase
                            w_op_head = CELL_PUSH;
                            w_op_tail = CELL_POP;
                            n_count   = r_count - CNT_W'(1);
                        end
                    end else begin
                        w_emit        = 1'b1;
                        w_emit_status = ST_SYMBOL;
                    end

                    if (!r_err_seen && !w_emit && !w_div_start && i_sym.last) begin
                        w_emit = 1'b1;
                        if (n_count == CNT_W'(1)) begin
                            w_emit_value = w_head_val;
                        end else begin
                            w_emit_status = ST_DEPTH;
                        end
                    end

                    if (!r_err_seen && w_emit) begin
                        n_count    = '0;
                        n_err_seen = (w_emit_status != ST_OK) && !i_sym.last;
                    end
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    w_head_val = w_quotient;
                    w_op_head  = CELL_PUSH;
                    w_op_tail  = CELL_POP;
                    n_count    = r_count - CNT_W'(1);
                    n_state    = S_IDLE;
                    if (r_last) begin
                        w_emit  = 1'b1;
                        n_count = '0;
                        if (r_count == CNT_W'(2)) begin
                            w_emit_value = w_quotient;
                        end else begin
                            w_emit_status = ST_DEPTH;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_err_seen  <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_err_seen <= n_err_seen;
            r_last     <= n_last;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_value  <= w_emit_value;
            r_out_status <= w_emit_status;
        end
    end

    assign o_res.valid  = r_out_valid;
    assign o_res.value  = $signed(r_out_value);
    assign o_res.status = r_out_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_div_operands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_count >= CNT_W'(2)))
        else $error("division running without two operands");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside a division");

    a_err_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err_seen |-> (r_count == '0))
        else $error("stack not empty while dropping symbols");

endmodule
